/* hdl/ordered_array_insert_delete_search_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ordered array block
// Concurrent checks clocked on clk and held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_DEFINES_SVH

// Property that must hold at every clock edge.
`define OAIDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OAIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/oaids_pkg.sv */
// ---------------------------------------------------------------------------
// Ordered array package
// Sizes, opcodes, status codes and cell commands shared by the block.
// ---------------------------------------------------------------------------
package oaids_pkg;

	localparam int CAPACITY  = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int DATA_W    = 32;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		OP_TRAVERSE = 2'd0,
		OP_INSERT   = 2'd1,
		OP_DELETE   = 2'd2,
		OP_SEARCH   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// What a cell loads at the next edge.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_HEAD
	} cell_op_t;

endpackage

/* hdl/oaids_cell.sv */
// ---------------------------------------------------------------------------
// Ordered array cell
// One entry of the chain: loads a new word, a neighbour's word or the head
// word, and compares its entry with the search key.
// ---------------------------------------------------------------------------
module oaids_cell import oaids_pkg::*; (
	input  logic              clk,
	input  cell_op_t          op,
	input  logic [DATA_W-1:0] new_value,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic [DATA_W-1:0] head,
	input  logic [DATA_W-1:0] search_key,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_LOAD:  data_q <= new_value;
			CELL_LEFT:  data_q <= left;
			CELL_RIGHT: data_q <= right;
			CELL_HEAD:  data_q <= head;
			default:    data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == search_key);

endmodule

/* hdl/ordered_array_insert_delete_search.sv */
// Insert, delete and search give a registered result in the cycle after acceptance.
// Throughput: an edit or a search every cycle while the result side keeps up.
// Traverse of n entries holds off the input until the last entry is registered: after acceptance
// the cell chain rotates by one cell per cycle while the result slot is free, and the head cell
// feeds the output register, one entry per rotation step; an empty store answers like an edit.
// Reset: count cleared, controller idle, no result pending; entries not cleared.
// ---------------------------------------------------------------------------
// Ordered array with insert, delete and search
// Positional list held in a chain of cells with a count of entries in use.
// ---------------------------------------------------------------------------
`include "ordered_array_insert_delete_search_defines.svh"

module ordered_array_insert_delete_search import oaids_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input transactions
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [3:0] position, [35:4] new_value, [67:36] search_key, [71:68] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [1:0] opcode
	input  logic [1:0]           s_tuser,
	// Result transactions
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] element, [35:32] index, [40:36] count_now, [47:41] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]           m_tuser,
	output logic                 m_tlast
);

	typedef enum logic {
		S_IDLE,
		S_TRAV
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   trav_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [DATA_W-1:0]  out_element_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_last_q;

	// Unpack the input transaction
	op_t                opcode;
	logic [CNT_W-1:0]   pos;
	logic [DATA_W-1:0]  new_value;
	logic [DATA_W-1:0]  search_key;

	assign opcode     = op_t'(s_tuser);
	assign pos        = {1'b0, s_tdata[3:0]};
	assign new_value  = s_tdata[35:4];
	assign search_key = s_tdata[67:36];

	logic take;
	logic out_free;
	logic trav_step;
	logic trav_end;

	// A result slot is free when empty or when its transaction completes now
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign take      = s_tvalid && s_tready;
	assign trav_step = (state_q == S_TRAV) && out_free;
	assign trav_end  = (({1'b0, trav_q} + CNT_W'(1)) == count_q);

	// Edit checks, decided on the count before this transaction
	logic ins_ok;
	logic del_ok;

	assign ins_ok = (count_q != CNT_W'(CAPACITY)) && (pos <= count_q);
	assign del_ok = (pos < count_q);

	// Cell chain
	cell_op_t          cell_op [CAPACITY];
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_op[i] = CELL_HOLD;
			if (take && (opcode == OP_INSERT) && ins_ok) begin
				// Open a gap at the position and shift later entries up
				if (CNT_W'(i) == pos) begin
					cell_op[i] = CELL_LOAD;
				end else if ((CNT_W'(i) > pos) && (CNT_W'(i) <= count_q)) begin
					cell_op[i] = CELL_LEFT;
				end
			end else if (take && (opcode == OP_DELETE) && del_ok) begin
				// Close the gap by shifting later entries down
				if ((CNT_W'(i) >= pos) && ((CNT_W'(i) + CNT_W'(1)) < count_q)) begin
					cell_op[i] = CELL_RIGHT;
				end
			end else if (trav_step) begin
				// Rotate the used part of the chain: after n steps it is back in place
				if ((CNT_W'(i) + CNT_W'(1)) < count_q) begin
					cell_op[i] = CELL_RIGHT;
				end else if ((CNT_W'(i) + CNT_W'(1)) == count_q) begin
					cell_op[i] = CELL_HEAD;
				end
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_end
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end

		oaids_cell u_cell (
			.clk        (clk),
			.op         (cell_op[g]),
			.new_value  (new_value),
			.left       (left_d),
			.right      (right_d),
			.head       (cell_data[0]),
			.search_key (search_key),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	// Lowest used cell that holds the key
	logic             found;
	logic [IDX_W-1:0] found_idx;

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CNT_W'(i) < count_q)) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
		end
	end

	// Controller: state, count and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			trav_q        <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_OK;
			out_element_q <= '0;
			out_index_q   <= '0;
			out_count_q   <= '0;
			out_last_q    <= 1'b0;
		end else begin
			priority if (take) begin
				out_element_q <= '0;
				out_last_q    <= 1'b1;
				unique case (opcode)
					OP_TRAVERSE: begin
						// An empty store answers at once; otherwise start the rotation
						out_valid_q  <= (count_q == '0);
						out_status_q <= ST_EMPTY;
						out_index_q  <= '0;
						out_count_q  <= count_q;
						if (count_q != '0) begin
							state_q <= S_TRAV;
							trav_q  <= '0;
						end
					end
					OP_INSERT: begin
						out_valid_q <= 1'b1;
						out_index_q <= '0;
						if (count_q == CNT_W'(CAPACITY)) begin
							out_status_q <= ST_FULL;
							out_count_q  <= count_q;
						end else if (!ins_ok) begin
							out_status_q <= ST_BAD_POS;
							out_count_q  <= count_q;
						end else begin
							out_status_q <= ST_OK;
							out_count_q  <= count_q + CNT_W'(1);
							count_q      <= count_q + CNT_W'(1);
						end
					end
					OP_DELETE: begin
						out_valid_q <= 1'b1;
						out_index_q <= '0;
						if (!del_ok) begin
							out_status_q <= ST_BAD_POS;
							out_count_q  <= count_q;
						end else begin
							out_status_q <= ST_OK;
							out_count_q  <= count_q - CNT_W'(1);
							count_q      <= count_q - CNT_W'(1);
						end
					end
					default: begin
						out_valid_q  <= 1'b1;
						out_status_q <= found ? ST_OK : ST_NOT_FOUND;
						out_index_q  <= found_idx;
						out_count_q  <= count_q;
					end
				endcase
			end else if (trav_step) begin
				// Emit the head entry and advance the rotation
				out_valid_q   <= 1'b1;
				out_status_q  <= ST_OK;
				out_element_q <= cell_data[0];
				out_index_q   <= trav_q;
				out_count_q   <= count_q;
				out_last_q    <= trav_end;
				trav_q        <= trav_q + IDX_W'(1);
				if (trav_end) begin
					state_q <= S_IDLE;
				end
			end else if (m_tready) begin
				// Drop a result once its transaction completes
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_count_q, out_index_q, out_element_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// Checks
	`OAIDS_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`OAIDS_ASSERT_NEXT(a_count_hold, !take, $stable(count_q), "count moved with no transaction")
	`OAIDS_ASSERT(a_trav_nonempty, (state_q != S_TRAV) || (count_q != '0), "traverse of empty store")
	`OAIDS_ASSERT(a_trav_index, (state_q != S_TRAV) || ({1'b0, trav_q} < count_q), "traverse index past end")

endmodule
